// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int TAB_STOP = 8;

  // derived widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COLX_W = $clog2(2 * COLUMNS);
  localparam int STEP_W = $clog2(COLUMNS + 1);
  localparam int TAB_W  = $clog2(TAB_STOP);

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int POS_W    = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  // widths for saturating the requested column and row
  localparam int COLC_W = (COL_IN_W > COL_W) ? COL_IN_W : COL_W;
  localparam int ROWC_W = (ROW_IN_W > ROW_W) ? ROW_IN_W : ROW_W;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 2'd0,
    FN_SET   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } tcw_func_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic copy;
    logic fill;
    logic fill_zero;
    logic finish;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic op_clear;
    logic scroll;
    logic copy_last;
    logic fill_last;
  } tcw_status_t;

endpackage

// ===== design/text_console_writer.sv =====
// Set cursor and put of a character, newline or tab without scroll pass through the execute
// state to the strobe; read cell adds a read state for the registered store read.
// Clear screen and a put that scrolls sweep the store one cell a cycle through its single
// write port on the 80 x 25 screen.
// Throughput: one operation at a time, busy high meanwhile; a new start is taken as strobe shows.
// Reset: rst zeroes the store in a clearing pass over the whole store with busy high.
module text_console_writer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::FUNC_W-1:0]   func,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::COL_IN_W-1:0] col,
  input  logic [tcw_pkg::ROW_IN_W-1:0] row,
  output logic                         done,
  output logic [tcw_pkg::POS_W-1:0]    cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]   cell_attr,
  output logic                         scrolled,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]   text_attribute
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t st;

  // attribute register takes a transfer in any cycle
  assign cfg_ready = 1'b1;

  // controller
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath with the screen store
  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .func       (func),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_attr   (text_attribute),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .scrolled   (scrolled)
  );

endmodule

// ===== design/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t    cmd,
  output logic                 busy
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_READ  = 6'b001000,
    S_COPY  = 6'b010000,
    S_BLANK = 6'b100000
  } tcw_state_t;

  tcw_state_t state;
  tcw_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one operation
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.fill      = 1'b1;
        cmd.fill_zero = 1'b1;
        if (st.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.op_read) begin
          state_next = S_READ;
        end else if (st.op_clear) begin
          state_next = S_BLANK;
        end else if (st.scroll) begin
          state_next = S_COPY;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (st.copy_last) begin
          state_next = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.fill = 1'b1;
        if (st.fill_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // a put that overflows must go on to move the rows
  a_scroll_copies: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !st.op_read && !st.op_clear && st.scroll) |=> (state == S_COPY))
    else $error("overflowing put did not start the row move");

  // row move always ends in blanking the last row
  a_copy_blank: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && st.copy_last) |=> (state == S_BLANK))
    else $error("row move did not hand over to blanking");

endmodule

// ===== design/tcw_datapath.sv =====
module tcw_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tcw_pkg::tcw_cmd_t              cmd,
  output tcw_pkg::tcw_status_t           st,
  input  logic [tcw_pkg::FUNC_W-1:0]     func,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::COL_IN_W-1:0]   col,
  input  logic [tcw_pkg::ROW_IN_W-1:0]   row,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_attr,
  output logic                           done,
  output logic [tcw_pkg::POS_W-1:0]      cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attr,
  output logic                           scrolled
);
  import tcw_pkg::*;

  // operation registers
  tcw_func_t            func_q;
  logic [CHAR_W-1:0]    char_q;
  logic [COL_IN_W-1:0]  col_q;
  logic [ROW_IN_W-1:0]  row_q;

  logic [ATTR_W-1:0]    attr;
  logic [ADDR_W-1:0]    cursor;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [ADDR_W-1:0]    cursor_next;
  logic [COL_W-1:0]     cur_col_next;
  logic [ROW_W-1:0]     cur_row_next;
  logic [ADDR_W-1:0]    cnt;
  logic                 scroll_hit;

  // screen store
  logic [CELL_W-1:0]    mem [CELLS];
  logic [CELL_W-1:0]    rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CELL_W-1:0]    wr_data;

  // put arithmetic
  logic [STEP_W-1:0]    step;
  logic [COLX_W-1:0]    col_sum;
  logic                 wrap;
  logic [COL_W-1:0]     put_col;
  logic [ROW_W-1:0]     put_row;
  logic                 ovf;
  logic                 put_we;

  // saturated addressing for set and read
  logic [COLC_W-1:0]    col_ext;
  logic [ROWC_W-1:0]    row_ext;
  logic [COL_W-1:0]     sat_col;
  logic [ROW_W-1:0]     sat_row;
  logic [ADDR_W-1:0]    sat_pos;
  logic [ADDR_W-1:0]    copy_src;

  // capture operation on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= tcw_func_t'(func);
      char_q <= char_code;
      col_q  <= col;
      row_q  <= row;
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_attr;
    end
  end

  // clamp requested position
  always_comb begin
    col_ext = COLC_W'(col_q);
    row_ext = ROWC_W'(row_q);
    if (col_ext > COLC_W'(COLUMNS - 1)) begin
      sat_col = COL_W'(COLUMNS - 1);
    end else begin
      sat_col = COL_W'(col_ext);
    end
    if (row_ext > ROWC_W'(ROWS - 1)) begin
      sat_row = ROW_W'(ROWS - 1);
    end else begin
      sat_row = ROW_W'(row_ext);
    end
    sat_pos = ADDR_W'(ADDR_W'(sat_row) * ADDR_W'(COLUMNS)) + ADDR_W'(sat_col);
  end

  // cursor advance for newline, tab and printable bytes
  always_comb begin
    if (char_q == CH_NEWLINE) begin
      step = STEP_W'(COLUMNS) - STEP_W'(cur_col);
    end else if (char_q == CH_TAB) begin
      step = STEP_W'(TAB_STOP) - STEP_W'(cursor[TAB_W-1:0]);
    end else begin
      step = STEP_W'(1);
    end
    col_sum = COLX_W'(cur_col) + COLX_W'(step);
    wrap    = (col_sum >= COLX_W'(COLUMNS));
    if (wrap) begin
      put_col = COL_W'(col_sum - COLX_W'(COLUMNS));
      put_row = cur_row + ROW_W'(1);
    end else begin
      put_col = COL_W'(col_sum);
      put_row = cur_row;
    end
    ovf    = wrap && (cur_row == ROW_W'(ROWS - 1));
    put_we = (char_q != CH_NEWLINE) && (char_q != CH_TAB);
  end

  // next cursor
  always_comb begin
    cursor_next  = cursor;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (cmd.exec) begin
      case (func_q)
        FN_PUT: begin
          if (ovf) begin
            cursor_next  = ADDR_W'(CELLS - COLUMNS);
            cur_col_next = '0;
            cur_row_next = ROW_W'(ROWS - 1);
          end else begin
            cursor_next  = cursor + ADDR_W'(step);
            cur_col_next = put_col;
            cur_row_next = put_row;
          end
        end
        FN_SET: begin
          cursor_next  = sat_pos;
          cur_col_next = sat_col;
          cur_row_next = sat_row;
        end
        FN_CLEAR: begin
          cursor_next  = '0;
          cur_col_next = '0;
          cur_row_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      cursor  <= cursor_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  // sweep counter for clearing and the row move
  always_ff @(posedge clk) begin
    if (rst || cmd.exec) begin
      cnt <= '0;
    end else if ((cmd.copy && !st.copy_last) || (cmd.fill && !st.fill_last)) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_hit <= 1'b0;
    end else if (cmd.exec) begin
      scroll_hit <= (func_q == FN_PUT) && ovf;
    end
  end

  // status to the controller
  always_comb begin
    st.op_read   = (func_q == FN_READ);
    st.op_clear  = (func_q == FN_CLEAR);
    st.scroll    = (func_q == FN_PUT) && ovf;
    st.copy_last = (cnt == ADDR_W'(CELLS - COLUMNS));
    st.fill_last = (cnt == ADDR_W'(CELLS - 1));
  end

  // store write and read selection; the move reads one row ahead of its write
  always_comb begin
    copy_src = cnt + ADDR_W'(COLUMNS);
    we       = 1'b0;
    wr_addr  = cnt;
    wr_data  = '0;
    if (cmd.fill) begin
      we      = 1'b1;
      wr_data = cmd.fill_zero ? '0 : {attr, CH_SPACE};
    end else if (cmd.copy) begin
      we      = (cnt != '0);
      wr_addr = cnt - ADDR_W'(1);
      wr_data = rd_data;
    end else if (cmd.exec && func_q == FN_PUT && put_we) begin
      we      = 1'b1;
      wr_addr = cursor;
      wr_data = {attr, char_q};
    end
    if (cmd.copy) begin
      rd_addr = st.copy_last ? cnt : copy_src;
    end else begin
      rd_addr = sat_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cursor_pos <= POS_W'(cursor_next);
      scrolled   <= cmd.exec ? 1'b0 : scroll_hit;
      if (func_q == FN_READ) begin
        cell_char <= rd_data[CHAR_W-1:0];
        cell_attr <= rd_data[CELL_W-1:CHAR_W];
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
    end
  end

  // cursor stays on the screen and matches its row and column
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor < ADDR_W'(CELLS)) &&
    (cursor == ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col)))
    else $error("cursor offset out of step with row and column");

  // the store is only written while an operation or the clearing pass runs
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec || cmd.copy || cmd.fill) |-> !we)
    else $error("store written while idle");

  // a result strobe is never held high
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held high");

endmodule
